FILE: rtl/core/rvde_pkg.sv
// Shared opcodes, function codes and decode types of the RV32I execute unit.
package rvde_pkg;

  localparam logic [6:0] OpcR      = 7'b0110011;
  localparam logic [6:0] OpcI      = 7'b0010011;
  localparam logic [6:0] OpcLoad   = 7'b0000011;
  localparam logic [6:0] OpcStore  = 7'b0100011;
  localparam logic [6:0] OpcBranch = 7'b1100011;

  localparam logic [2:0] F3AddSub = 3'b000;
  localparam logic [2:0] F3Sll    = 3'b001;
  localparam logic [2:0] F3Xor    = 3'b100;
  localparam logic [2:0] F3Shr    = 3'b101;
  localparam logic [2:0] F3Or     = 3'b110;
  localparam logic [2:0] F3And    = 3'b111;

  localparam logic [2:0] F3Beq  = 3'b000;
  localparam logic [2:0] F3Bne  = 3'b001;
  localparam logic [2:0] F3Blt  = 3'b100;
  localparam logic [2:0] F3Bge  = 3'b101;
  localparam logic [2:0] F3Bltu = 3'b110;
  localparam logic [2:0] F3Bgeu = 3'b111;

  typedef enum logic [2:0] {
    AluAdd,
    AluSub,
    AluSll,
    AluSrl,
    AluSra,
    AluXor,
    AluOr,
    AluAnd
  } alu_op_e;

  typedef enum logic [2:0] {
    BrEq,
    BrNe,
    BrLt,
    BrGe,
    BrLtu,
    BrGeu
  } br_cond_e;

  typedef struct packed {
    logic     supported;
    logic     reg_write;
    logic     mem_read;
    logic     mem_write;
    logic     is_branch;
    logic     use_imm;
    alu_op_e  alu_op;
    br_cond_e br_cond;
  } ctrl_t;

endpackage

FILE: rtl/core/rvde_decode.sv
// Instruction decoder: control bits, ALU operation and immediates.
module rvde_decode (
  input  logic [31:0]   instr_i,
  output rvde_pkg::ctrl_t ctrl_o,
  output logic [31:0]   imm_o,
  output logic [31:0]   imm_b_o
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic       alt;
  logic [31:0] imm_i;
  logic [31:0] imm_s;

  assign opc   = instr_i[6:0];
  assign f3    = instr_i[14:12];
  assign alt   = instr_i[30];
  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b_o = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                    instr_i[11:8], 1'b0};

  always_comb begin
    ctrl_o = '0;
    ctrl_o.alu_op  = rvde_pkg::AluAdd;
    ctrl_o.br_cond = rvde_pkg::BrEq;
    imm_o = imm_i;
    unique case (opc)
      rvde_pkg::OpcR, rvde_pkg::OpcI: begin
        ctrl_o.use_imm   = (opc == rvde_pkg::OpcI);
        ctrl_o.supported = 1'b1;
        unique case (f3)
          rvde_pkg::F3AddSub: ctrl_o.alu_op = (alt && opc == rvde_pkg::OpcR) ?
                                              rvde_pkg::AluSub : rvde_pkg::AluAdd;
          rvde_pkg::F3Sll:    ctrl_o.alu_op = rvde_pkg::AluSll;
          rvde_pkg::F3Xor:    ctrl_o.alu_op = rvde_pkg::AluXor;
          rvde_pkg::F3Shr:    ctrl_o.alu_op = alt ? rvde_pkg::AluSra : rvde_pkg::AluSrl;
          rvde_pkg::F3Or:     ctrl_o.alu_op = rvde_pkg::AluOr;
          rvde_pkg::F3And:    ctrl_o.alu_op = rvde_pkg::AluAnd;
          default:            ctrl_o.supported = 1'b0;
        endcase
        ctrl_o.reg_write = ctrl_o.supported;
      end
      rvde_pkg::OpcLoad: begin
        ctrl_o.supported = 1'b1;
        ctrl_o.reg_write = 1'b1;
        ctrl_o.mem_read  = 1'b1;
        ctrl_o.use_imm   = 1'b1;
      end
      rvde_pkg::OpcStore: begin
        ctrl_o.supported = 1'b1;
        ctrl_o.mem_write = 1'b1;
        ctrl_o.use_imm   = 1'b1;
        imm_o = imm_s;
      end
      rvde_pkg::OpcBranch: begin
        ctrl_o.supported = 1'b1;
        unique case (f3)
          rvde_pkg::F3Beq:  ctrl_o.br_cond = rvde_pkg::BrEq;
          rvde_pkg::F3Bne:  ctrl_o.br_cond = rvde_pkg::BrNe;
          rvde_pkg::F3Blt:  ctrl_o.br_cond = rvde_pkg::BrLt;
          rvde_pkg::F3Bge:  ctrl_o.br_cond = rvde_pkg::BrGe;
          rvde_pkg::F3Bltu: ctrl_o.br_cond = rvde_pkg::BrLtu;
          rvde_pkg::F3Bgeu: ctrl_o.br_cond = rvde_pkg::BrGeu;
          default:          ctrl_o.supported = 1'b0;
        endcase
        ctrl_o.is_branch = ctrl_o.supported;
      end
      default: ctrl_o = ctrl_o;
    endcase
  end

endmodule

FILE: rtl/core/rvde_alu.sv
// ALU, branch comparator and branch target adder.
module rvde_alu (
  input  rvde_pkg::ctrl_t ctrl_i,
  input  logic [31:0]   src1_i,
  input  logic [31:0]   src2_i,
  input  logic [31:0]   imm_i,
  input  logic [31:0]   imm_b_i,
  input  logic [31:0]   pc_i,
  output logic [31:0]   result_o,
  output logic          taken_o,
  output logic [31:0]   target_o
);

  logic [31:0] op_b;
  logic [4:0]  shamt;
  logic        lt_s;
  logic        lt_u;

  assign op_b  = ctrl_i.use_imm ? imm_i : src2_i;
  assign shamt = op_b[4:0];
  assign lt_s  = $signed(src1_i) < $signed(src2_i);
  assign lt_u  = src1_i < src2_i;
  assign target_o = pc_i + imm_b_i;

  always_comb begin
    unique case (ctrl_i.alu_op)
      rvde_pkg::AluAdd: result_o = src1_i + op_b;
      rvde_pkg::AluSub: result_o = src1_i - op_b;
      rvde_pkg::AluSll: result_o = src1_i << shamt;
      rvde_pkg::AluSrl: result_o = src1_i >> shamt;
      rvde_pkg::AluSra: result_o = 32'($signed(src1_i) >>> shamt);
      rvde_pkg::AluXor: result_o = src1_i ^ op_b;
      rvde_pkg::AluOr:  result_o = src1_i | op_b;
      rvde_pkg::AluAnd: result_o = src1_i & op_b;
      default:          result_o = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.br_cond)
      rvde_pkg::BrEq:  taken_o = (src1_i == src2_i);
      rvde_pkg::BrNe:  taken_o = (src1_i != src2_i);
      rvde_pkg::BrLt:  taken_o = lt_s;
      rvde_pkg::BrGe:  taken_o = !lt_s;
      rvde_pkg::BrLtu: taken_o = lt_u;
      rvde_pkg::BrGeu: taken_o = !lt_u;
      default:         taken_o = 1'b0;
    endcase
  end

endmodule

FILE: rtl/core/rv32i_decode_and_execute.sv
// Top level of the RV32I decode and execute unit with input and result registers.
// Each request carries one instruction, its PC and both source values and yields
// exactly one result, captured in the input register and then the result register. A new
// request is taken every cycle while the result side is not stalled; the rate is set by
// the single pass through the decoder and ALU between the input register and the result
// register. Unsupported instructions give all-zero outputs with supported low.
module rv32i_decode_and_execute (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        instr_i,
  input  logic [31:0]        pc_addr_i,
  input  logic signed [31:0] src1_value_i,
  input  logic signed [31:0] src2_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] alu_result_o,
  output logic signed [31:0] store_data_o,
  output logic [4:0]         dest_reg_o,
  output logic               reg_write_o,
  output logic               mem_read_o,
  output logic               mem_write_o,
  output logic               load_to_reg_o,
  output logic               is_branch_o,
  output logic               branch_taken_o,
  output logic [31:0]        branch_target_o,
  output logic               supported_o
);

  logic        in_valid_q;
  logic [31:0] instr_q;
  logic [31:0] pc_q;
  logic [31:0] src1_q;
  logic [31:0] src2_q;
  logic        out_valid_q;
  logic        out_ready;
  logic        in_advance;

  rvde_pkg::ctrl_t ctrl;
  logic [31:0] imm;
  logic [31:0] imm_b;
  logic [31:0] alu_res;
  logic        taken;
  logic [31:0] target;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_advance = !in_valid_q || out_ready;
  assign in_stall_o = !in_advance;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_advance) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_advance && in_valid_i) begin
      instr_q <= instr_i;
      pc_q    <= pc_addr_i;
      src1_q  <= src1_value_i;
      src2_q  <= src2_value_i;
    end
  end

  rvde_decode u_decode (
    .instr_i (instr_q),
    .ctrl_o  (ctrl),
    .imm_o   (imm),
    .imm_b_o (imm_b)
  );

  rvde_alu u_alu (
    .ctrl_i   (ctrl),
    .src1_i   (src1_q),
    .src2_i   (src2_q),
    .imm_i    (imm),
    .imm_b_i  (imm_b),
    .pc_i     (pc_q),
    .result_o (alu_res),
    .taken_o  (taken),
    .target_o (target)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid_q && out_ready) begin
      alu_result_o    <= (ctrl.supported && !ctrl.is_branch) ? alu_res : '0;
      store_data_o    <= ctrl.mem_write ? src2_q : '0;
      dest_reg_o      <= ctrl.reg_write ? instr_q[11:7] : '0;
      reg_write_o     <= ctrl.reg_write;
      mem_read_o      <= ctrl.mem_read;
      mem_write_o     <= ctrl.mem_write;
      load_to_reg_o   <= ctrl.mem_read;
      is_branch_o     <= ctrl.is_branch;
      branch_taken_o  <= ctrl.is_branch && taken;
      branch_target_o <= ctrl.is_branch ? target : '0;
      supported_o     <= ctrl.supported;
    end
  end

endmodule

FILE: sim/rvde_exec_checker.sv
// Checker for the RV32I execute unit: predicts each result and compares it with the output.
module rvde_exec_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] instr_i,
  input  logic [31:0] pc_addr_i,
  input  logic [31:0] src1_value_i,
  input  logic [31:0] src2_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] alu_result_i,
  input  logic [31:0] store_data_i,
  input  logic [4:0]  dest_reg_i,
  input  logic        reg_write_i,
  input  logic        mem_read_i,
  input  logic        mem_write_i,
  input  logic        load_to_reg_i,
  input  logic        is_branch_i,
  input  logic        branch_taken_i,
  input  logic [31:0] branch_target_i,
  input  logic        supported_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] alu_result;
    logic [31:0] store_data;
    logic [4:0]  dest_reg;
    logic        reg_write;
    logic        mem_read;
    logic        mem_write;
    logic        load_to_reg;
    logic        is_branch;
    logic        branch_taken;
    logic [31:0] branch_target;
    logic        supported;
  } exec_res_t;

  exec_res_t exec_q[$];
  int        errs = 0;
  int        depth = 0;

  assign errors_o  = errs;
  assign pending_o = depth;

  function automatic exec_res_t predict_exec(input logic [31:0] ins, input logic [31:0] pc,
                                             input logic [31:0] a, input logic [31:0] b);
    exec_res_t   r;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] opnd;
    logic [31:0] res;
    logic [4:0]  sh;
    logic        ok;
    r     = '0;
    res   = '0;
    ok    = 1'b0;
    opc   = ins[6:0];
    f3    = ins[14:12];
    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    case (opc)
      rvde_pkg::OpcR, rvde_pkg::OpcI: begin
        opnd = (opc == rvde_pkg::OpcR) ? b : imm_i;
        sh   = opnd[4:0];
        ok   = 1'b1;
        case (f3)
          rvde_pkg::F3AddSub: res = (ins[30] && opc == rvde_pkg::OpcR) ? a - opnd : a + opnd;
          rvde_pkg::F3Sll:    res = a << sh;
          rvde_pkg::F3Xor:    res = a ^ opnd;
          rvde_pkg::F3Shr: begin
            if (ins[30]) res = $signed(a) >>> sh;
            else res = a >> sh;
          end
          rvde_pkg::F3Or:     res = a | opnd;
          rvde_pkg::F3And:    res = a & opnd;
          default:            ok = 1'b0;
        endcase
        if (ok) begin
          r.alu_result = res;
          r.reg_write  = 1'b1;
          r.dest_reg   = ins[11:7];
          r.supported  = 1'b1;
        end
      end
      rvde_pkg::OpcLoad: begin
        r.alu_result  = a + imm_i;
        r.reg_write   = 1'b1;
        r.dest_reg    = ins[11:7];
        r.mem_read    = 1'b1;
        r.load_to_reg = 1'b1;
        r.supported   = 1'b1;
      end
      rvde_pkg::OpcStore: begin
        r.alu_result = a + imm_s;
        r.store_data = b;
        r.mem_write  = 1'b1;
        r.supported  = 1'b1;
      end
      rvde_pkg::OpcBranch: begin
        ok = 1'b1;
        case (f3)
          rvde_pkg::F3Beq:  r.branch_taken = (a == b);
          rvde_pkg::F3Bne:  r.branch_taken = (a != b);
          rvde_pkg::F3Blt:  r.branch_taken = ($signed(a) < $signed(b));
          rvde_pkg::F3Bge:  r.branch_taken = ($signed(a) >= $signed(b));
          rvde_pkg::F3Bltu: r.branch_taken = (a < b);
          rvde_pkg::F3Bgeu: r.branch_taken = (a >= b);
          default:          ok = 1'b0;
        endcase
        if (ok) begin
          r.is_branch     = 1'b1;
          r.branch_target = pc + imm_b;
          r.supported     = 1'b1;
        end else begin
          r = '0;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_error(input string msg);
    errs = errs + 1;
    if (errs <= 100) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    exec_res_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (exec_q.size() == 0) begin
          report_error("result with no request outstanding");
        end else begin
          want = exec_q.pop_front();
          check_field("alu_result", alu_result_i, want.alu_result);
          check_field("store_data", store_data_i, want.store_data);
          check_field("dest_reg", 32'(dest_reg_i), 32'(want.dest_reg));
          check_field("reg_write", 32'(reg_write_i), 32'(want.reg_write));
          check_field("mem_read", 32'(mem_read_i), 32'(want.mem_read));
          check_field("mem_write", 32'(mem_write_i), 32'(want.mem_write));
          check_field("load_to_reg", 32'(load_to_reg_i), 32'(want.load_to_reg));
          check_field("is_branch", 32'(is_branch_i), 32'(want.is_branch));
          check_field("branch_taken", 32'(branch_taken_i), 32'(want.branch_taken));
          check_field("branch_target", branch_target_i, want.branch_target);
          check_field("supported", 32'(supported_i), 32'(want.supported));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        exec_q = {exec_q, predict_exec(instr_i, pc_addr_i, src1_value_i, src2_value_i)};
      end
      depth <= exec_q.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// Testbench top for the RV32I execute unit: stimulus, receiver stalls, watchdog and verdict.
module testbench;

  localparam logic [6:0] OpcLui    = 7'b0110111;
  localparam logic [2:0] F3Slt     = 3'b010;
  localparam logic [2:0] F3Sltu    = 3'b011;
  localparam logic [6:0] F7Base    = 7'b0000000;
  localparam logic [6:0] F7Alt     = 7'b0100000;
  localparam logic [6:0] F7All     = 7'b1111111;
  localparam logic [6:0] F7NoAlt   = 7'b1011111;
  localparam int         IdleLimit = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        instr = '0;
  logic [31:0]        pc_addr = '0;
  logic signed [31:0] src1_value = '0;
  logic signed [31:0] src2_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] alu_result;
  logic signed [31:0] store_data;
  logic [4:0]         dest_reg;
  logic               reg_write;
  logic               mem_read;
  logic               mem_write;
  logic               load_to_reg;
  logic               is_branch;
  logic               branch_taken;
  logic [31:0]        branch_target;
  logic               supported;
  int                 errors;
  int                 pending;
  int                 burst_left = 0;
  int                 idle_cycles = 0;
  int                 stall_cycle = 0;

  rv32i_decode_and_execute u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .instr_i         (instr),
    .pc_addr_i       (pc_addr),
    .src1_value_i    (src1_value),
    .src2_value_i    (src2_value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .alu_result_o    (alu_result),
    .store_data_o    (store_data),
    .dest_reg_o      (dest_reg),
    .reg_write_o     (reg_write),
    .mem_read_o      (mem_read),
    .mem_write_o     (mem_write),
    .load_to_reg_o   (load_to_reg),
    .is_branch_o     (is_branch),
    .branch_taken_o  (branch_taken),
    .branch_target_o (branch_target),
    .supported_o     (supported)
  );

  rvde_exec_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .instr_i         (instr),
    .pc_addr_i       (pc_addr),
    .src1_value_i    (src1_value),
    .src2_value_i    (src2_value),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .alu_result_i    (alu_result),
    .store_data_i    (store_data),
    .dest_reg_i      (dest_reg),
    .reg_write_i     (reg_write),
    .mem_read_i      (mem_read),
    .mem_write_i     (mem_write),
    .load_to_reg_i   (load_to_reg),
    .is_branch_i     (is_branch),
    .branch_taken_i  (branch_taken),
    .branch_target_i (branch_target),
    .supported_i     (supported),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // The receiver cycles through modes: no stalls, random, periodic and sparse.
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 97) % 4)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      2:       out_stall <= (stall_cycle % 7) < 3;
      default: out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog expired after %0d cycles without a request.", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [31:0] mk_r(input logic [6:0] f7, input logic [2:0] f3);
    return {f7, 5'd2, 5'd1, f3, 5'd3, rvde_pkg::OpcR};
  endfunction

  function automatic logic [31:0] mk_i(input logic [11:0] imm, input logic [2:0] f3,
                                       input logic [6:0] opc);
    return {imm, 5'd1, f3, 5'd5, opc};
  endfunction

  function automatic logic [31:0] mk_s(input logic [11:0] imm, input logic [2:0] f3);
    return {imm[11:5], 5'd2, 5'd1, f3, imm[4:0], rvde_pkg::OpcStore};
  endfunction

  function automatic logic [31:0] mk_b(input logic [12:0] imm, input logic [2:0] f3);
    return {imm[12], imm[10:5], 5'd2, 5'd1, f3, imm[4:1], imm[11], rvde_pkg::OpcBranch};
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(0, 63);
      5:       return 32'hFFFF_FFFF - $urandom_range(0, 63);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed instructions with random fields, plus near-miss and raw words.
  function automatic logic [31:0] pick_instr();
    logic [31:0] ins;
    ins = $urandom;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        ins[6:0] = rvde_pkg::OpcR;
        if ($urandom_range(0, 3) != 0) ins[31:25] = $urandom_range(0, 1) ? F7Alt : F7Base;
      end
      4, 5, 6, 7: begin
        ins[6:0] = rvde_pkg::OpcI;
        if ($urandom_range(0, 1) != 0) ins[31:25] = $urandom_range(0, 1) ? F7Alt : F7Base;
      end
      8, 9:               ins[6:0] = rvde_pkg::OpcLoad;
      10, 11:             ins[6:0] = rvde_pkg::OpcStore;
      12, 13, 14, 15, 16: ins[6:0] = rvde_pkg::OpcBranch;
      17:                 ins[6:0] = rvde_pkg::OpcR ^ (7'd1 << $urandom_range(0, 6));
      default:            ;
    endcase
    return ins;
  endfunction

  task automatic issue(input logic [31:0] ins, input logic [31:0] pc,
                       input logic [31:0] a, input logic [31:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left = burst_left - 1;
    instr      <= ins;
    pc_addr    <= pc;
    src1_value <= a;
    src2_value <= b;
    in_valid   <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    burst_left = 0;
  endtask

  initial begin
    logic [31:0] ins;
    logic [31:0] a;
    logic [31:0] b;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue(mk_r(F7Base, rvde_pkg::F3AddSub), 32'h0, 32'h7FFF_FFFF, 32'h1);
    issue(mk_r(F7Alt, rvde_pkg::F3AddSub), 32'h4, 32'h8000_0000, 32'h1);
    issue(mk_r(F7All, rvde_pkg::F3AddSub), 32'h8, 32'h0, 32'h1);
    issue(mk_r(F7NoAlt, rvde_pkg::F3AddSub), 32'hC, 32'h5, 32'hFFFF_FFFD);
    issue(mk_r(F7Base, rvde_pkg::F3Sll), 32'h10, 32'hFFFF_FFFF, 32'd33);
    issue(mk_r(F7Base, rvde_pkg::F3Shr), 32'h14, 32'h8000_0000, 32'd31);
    issue(mk_r(F7Alt, rvde_pkg::F3Shr), 32'h18, 32'h8000_0000, 32'd63);
    issue(mk_r(F7Base, rvde_pkg::F3Xor), 32'h1C, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    issue(mk_r(F7Base, rvde_pkg::F3Or), 32'h20, 32'h0F0F_0000, 32'h0000_F0F0);
    issue(mk_r(F7Base, rvde_pkg::F3And), 32'h24, 32'hFFFF_FFFF, 32'h8000_0001);
    issue(mk_r(F7Base, F3Slt), 32'h28, 32'h1, 32'h2);
    issue(mk_i(12'h001, F3Sltu, rvde_pkg::OpcI), 32'h2C, 32'h1, 32'h2);
    issue(mk_i(12'h7FF, rvde_pkg::F3AddSub, rvde_pkg::OpcI), 32'h30, 32'h7FFF_FFFF, 32'h0);
    issue(mk_i(12'hC00, rvde_pkg::F3AddSub, rvde_pkg::OpcI), 32'h34, 32'h0, 32'h0);
    issue(mk_i({F7Alt, 5'd31}, rvde_pkg::F3Shr, rvde_pkg::OpcI), 32'h38, 32'h8000_0000,
          32'h0);
    issue(mk_i({F7Base, 5'd4}, rvde_pkg::F3Shr, rvde_pkg::OpcI), 32'h3C, 32'hFFFF_FFFF,
          32'h0);
    issue(mk_i(12'hFFF, rvde_pkg::F3Sll, rvde_pkg::OpcI), 32'h40, 32'h1, 32'h0);
    issue(mk_i(12'h800, rvde_pkg::F3And, rvde_pkg::OpcLoad), 32'h44, 32'h0, 32'hFFFF_FFFF);
    issue(mk_s(12'h7FF, rvde_pkg::F3Shr), 32'h48, 32'hFFFF_FFFF, 32'h8000_0000);
    issue(mk_b(13'h1FFE, rvde_pkg::F3Beq), 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    issue(mk_b(13'h0FFE, rvde_pkg::F3Bne), 32'hFFFF_FFFF, 32'h1, 32'h1);
    issue(mk_b(13'h1000, rvde_pkg::F3Blt), 32'h0000_0800, 32'hFFFF_FFFF, 32'h0);
    issue(mk_b(13'h0004, rvde_pkg::F3Bge), 32'h100, 32'h8000_0000, 32'h7FFF_FFFF);
    issue(mk_b(13'h0010, rvde_pkg::F3Bltu), 32'h200, 32'hFFFF_FFFF, 32'h0);
    issue(mk_b(13'h1FF0, rvde_pkg::F3Bgeu), 32'h300, 32'hFFFF_FFFF, 32'h0);
    issue(mk_b(13'h0008, F3Sltu), 32'h400, 32'h0, 32'h0);
    issue({25'h1FF_FFFF, OpcLui}, 32'h500, 32'h1, 32'h1);
    issue(32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    for (int n = 0; n < 700; n++) begin
      ins = pick_instr();
      a   = pick_operand();
      b   = ($urandom_range(0, 4) == 0) ? a : pick_operand();
      issue(ins, $urandom, a, b);
      if (n % 250 == 249) drain();
    end
    drain();
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: rv32i_decode_and_execute.f
rtl/core/rvde_pkg.sv
rtl/core/rvde_decode.sv
rtl/core/rvde_alu.sv
rtl/core/rv32i_decode_and_execute.sv
sim/rvde_exec_checker.sv
sim/testbench.sv
